>>> src/gmf_pkg.sv
package gmf_pkg;

  localparam int GRID_WORDS_DEF = 4096;
  localparam int WINDOW_MAX = 27;
  localparam int DIM_W = 9;
  localparam int CRD_W = 8;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_GATHER,
    ST_RANK_INIT,
    ST_RANK,
    ST_RANK_EVAL,
    ST_DONE,
    ST_ERROR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mem_wr;
    logic gather_start;
    logic gather_step;
    logic rank_init;
    logic rank_step;
    logic rank_eval;
    logic set_result;
    logic set_error;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic point_bad;
    logic write_bad;
    logic gather_done;
    logic gather_bad;
    logic rank_last;
    logic cand_found;
    logic cand_exhausted;
  } sts_t;

endpackage

>>> src/gmf_ctrl.sv
module gmf_ctrl
  import gmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.point_bad) state_nxt = ST_ERROR;
        else if (sts.is_query) state_nxt = ST_GATHER;
        else if (sts.write_bad) state_nxt = ST_ERROR;
        else state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_GATHER: begin
        if (sts.gather_bad) state_nxt = ST_ERROR;
        else if (sts.gather_done) state_nxt = ST_RANK_INIT;
      end
      ST_RANK_INIT: state_nxt = ST_RANK;
      ST_RANK: begin
        if (sts.rank_last) state_nxt = ST_RANK_EVAL;
      end
      ST_RANK_EVAL: begin
        if (sts.cand_found || sts.cand_exhausted) state_nxt = ST_DONE;
        else state_nxt = ST_RANK_INIT;
      end
      ST_DONE: state_nxt = ST_OUT;
      ST_ERROR: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK: cmd.gather_start = sts.is_query && !sts.point_bad;
      ST_WRITE: cmd.mem_wr = 1'b1;
      ST_GATHER: cmd.gather_step = 1'b1;
      ST_RANK_INIT: cmd.rank_init = 1'b1;
      ST_RANK: cmd.rank_step = 1'b1;
      ST_RANK_EVAL: cmd.rank_eval = 1'b1;
      ST_DONE: cmd.set_result = 1'b1;
      ST_ERROR: cmd.set_error = 1'b1;
      ST_OUT: cmd.out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

>>> src/gmf_dp.sv
module gmf_dp
  import gmf_pkg::*;
#(
  parameter int GRID_WORDS = GRID_WORDS_DEF
)(
  input  logic                     clk,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     rst_n,
  input  logic                     in_operation,
  input  logic [CRD_W-1:0]         in_x_coord,
  input  logic [CRD_W-1:0]         in_y_coord,
  input  logic [CRD_W-1:0]         in_z_coord,
  input  logic signed [DATA_W-1:0] in_sample_in,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic signed [DATA_W-1:0] out_median_value,
  output logic [CNT_W-1:0]         out_neighbour_count,
  output logic                     out_range_error
);

  localparam int AW = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
  localparam int WI_W = $clog2(WINDOW_MAX);
  localparam int WIDE_W = 2 * DIM_W + CRD_W + 2;
  localparam logic [WIDE_W-1:0] GW_LIM = WIDE_W'(GRID_WORDS);

  logic [DIM_W-1:0] dim_x_r, dim_y_r, dim_z_r;
  logic [2*DIM_W-1:0] dxy_r;
  logic op_r;
  logic [CRD_W-1:0] x_r, y_r, z_r;
  logic [DATA_W-1:0] sample_r;

  logic [DATA_W-1:0] mem [GRID_WORDS];
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] win [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= DIM_W'(1);
      dim_y_r <= DIM_W'(1);
      dim_z_r <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DIM_X: dim_x_r <= cfg_data;
        REG_DIM_Y: dim_y_r <= cfg_data;
        REG_DIM_Z: dim_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dxy_r <= dim_x_r * dim_y_r;
    if (cmd.load) begin
      op_r <= in_operation;
      x_r <= in_x_coord;
      y_r <= in_y_coord;
      z_r <= in_z_coord;
      sample_r <= in_sample_in;
    end
  end

  // cell address pipeline: offsets -> coords -> word (two multiplies, registered)
  logic [1:0] ox_r, oy_r, oz_r;
  logic gat_run_r, s1_v_r, s2_v_r, s3_v_r, s1_in_r;
  logic [WIDE_W-1:0] zt_r, yt_r, xt_r, word_r;
  logic s2_in_r, s3_in_r, bad_r, gend_r;
  logic [CNT_W-1:0] n_r;

  logic signed [DIM_W:0] xi, yi, zi;
  logic xin, yin, zin;
  logic last_off;
  assign xi = $signed({2'b0, x_r}) + $signed({{(DIM_W-1){1'b0}}, ox_r}) -
              $signed((DIM_W+1)'(1));
  assign yi = $signed({2'b0, y_r}) + $signed({{(DIM_W-1){1'b0}}, oy_r}) -
              $signed((DIM_W+1)'(1));
  assign zi = $signed({2'b0, z_r}) + $signed({{(DIM_W-1){1'b0}}, oz_r}) -
              $signed((DIM_W+1)'(1));
  assign xin = !xi[DIM_W] && (xi[DIM_W-1:0] < dim_x_r);
  assign yin = !yi[DIM_W] && (yi[DIM_W-1:0] < dim_y_r);
  assign zin = !zi[DIM_W] && (zi[DIM_W-1:0] < dim_z_r);
  assign last_off = (ox_r == 2'd2) && (oy_r == 2'd2) && (oz_r == 2'd2);

  logic [DIM_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [WIDE_W-1:0] wsum;
  assign wsum = zt_r + yt_r + xt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gat_run_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (cmd.gather_start) begin
        gat_run_r <= 1'b1;
        ox_r <= 2'd0; oy_r <= 2'd0; oz_r <= 2'd0;
      end else if (gat_run_r && cmd.gather_step) begin
        if (last_off) gat_run_r <= 1'b0;
        if (oz_r == 2'd2) begin
          oz_r <= 2'd0;
          if (oy_r == 2'd2) begin
            oy_r <= 2'd0;
            ox_r <= ox_r + 2'd1;
          end else oy_r <= oy_r + 2'd1;
        end else oz_r <= oz_r + 2'd1;
      end else if (!cmd.gather_step) begin
        gat_run_r <= 1'b0;
      end
      s1_v_r <= gat_run_r && cmd.gather_step;
      s2_v_r <= s1_v_r && cmd.gather_step;
      s3_v_r <= s2_v_r && cmd.gather_step;
    end
  end

  always_ff @(posedge clk) begin
    s1_in_r <= xin && yin && zin;
    s1_x_r <= xi[DIM_W-1:0];
    s1_y_r <= yi[DIM_W-1:0];
    s1_z_r <= zi[DIM_W-1:0];
    zt_r <= WIDE_W'(s1_z_r * dxy_r);
    yt_r <= WIDE_W'(s1_y_r * dim_x_r);
    xt_r <= WIDE_W'(s1_x_r);
    s2_in_r <= s1_in_r;
    word_r <= wsum;
    s3_in_r <= s2_in_r;
  end

  // final marker travels with the pipeline
  logic s1_last_r, s2_last_r, s3_last_r, s4_v_r;
  always_ff @(posedge clk) begin
    s1_last_r <= last_off;
    s2_last_r <= s1_last_r;
    s3_last_r <= s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r && cmd.gather_step && s3_in_r && (word_r < GW_LIM);
  end

  // write-word for write items
  logic [WIDE_W-1:0] wr_word;
  assign wr_word = WIDE_W'(z_r * dxy_r) + WIDE_W'(y_r * dim_x_r) + WIDE_W'(x_r);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[wr_word[AW-1:0]] <= sample_r;
    rd_data_r <= mem[word_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
      gend_r <= 1'b0;
      n_r <= '0;
    end else if (cmd.gather_start) begin
      bad_r <= 1'b0;
      gend_r <= 1'b0;
      n_r <= '0;
    end else if (cmd.gather_step) begin
      if (s3_v_r && s3_in_r && (word_r >= GW_LIM)) bad_r <= 1'b1;
      if (s3_v_r && s3_last_r) gend_r <= 1'b1;
      if (s4_v_r) begin
        win[n_r[WI_W-1:0]] <= rd_data_r;
        n_r <= n_r + CNT_W'(1);
      end
    end
  end

  logic s4_pend;
  assign s4_pend = s4_v_r;

  // ranking: candidate i vs all j, one j per cycle
  logic [CNT_W-1:0] ci_r, cj_r, half_r;
  logic [CNT_W-1:0] cnt_le_r, cnt_ge_r;
  logic lo_v_r, hi_v_r, found_r;
  logic [DATA_W-1:0] lo_k_r, hi_k_r, ki_r, res_r;
  logic skip_r;
  logic [DATA_W-1:0] kj;
  assign kj = win[cj_r[WI_W-1:0]] ^ {1'b1, {(DATA_W-1){1'b0}}};

  logic [CNT_W-1:0] half_c;
  always_comb begin
    half_c = n_r >> 1;
    if (!n_r[0] && half_c != '0) half_c = half_c - CNT_W'(1);
  end

  logic [DATA_W-1:0] ki_c;
  assign ki_c = win[ci_r[WI_W-1:0]] ^ {1'b1, {(DATA_W-1){1'b0}}};
  logic ok_lo, ok_hi;
  assign ok_lo = cnt_le_r >= half_r;
  assign ok_hi = cnt_ge_r >= half_r;

  always_ff @(posedge clk) begin
    if (cmd.gather_start) begin
      ci_r <= '0;
      lo_v_r <= 1'b0;
      hi_v_r <= 1'b0;
      found_r <= 1'b0;
    end
    if (cmd.rank_init) begin
      half_r <= half_c;
      ki_r <= ki_c;
      skip_r <= (lo_v_r && ki_c <= lo_k_r) || (hi_v_r && ki_c >= hi_k_r);
      cj_r <= '0;
      cnt_le_r <= '0;
      cnt_ge_r <= '0;
    end
    if (cmd.rank_step) begin
      if (cj_r != ci_r) begin
        if (kj <= ki_r) cnt_le_r <= cnt_le_r + CNT_W'(1);
        if (kj >= ki_r) cnt_ge_r <= cnt_ge_r + CNT_W'(1);
      end
      cj_r <= cj_r + CNT_W'(1);
    end
    if (cmd.rank_eval) begin
      if (!skip_r) begin
        if (!ok_lo) begin lo_v_r <= 1'b1; lo_k_r <= ki_r; end
        if (!ok_hi) begin hi_v_r <= 1'b1; hi_k_r <= ki_r; end
        if (ok_lo && ok_hi) found_r <= 1'b1;
      end
      if (skip_r || !(ok_lo && ok_hi)) ci_r <= ci_r + CNT_W'(1);
    end
  end

  logic eval_hit;
  assign eval_hit = !skip_r && ok_lo && ok_hi;

  always_ff @(posedge clk) begin
    if (cmd.set_error) begin
      out_median_value <= '0;
      out_neighbour_count <= '0;
      out_range_error <= 1'b1;
    end else if (cmd.set_result) begin
      out_median_value <= found_r ? res_r : win[0];
      out_neighbour_count <= n_r;
      out_range_error <= 1'b0;
    end
    if (cmd.rank_eval && eval_hit) res_r <= ki_r ^ {1'b1, {(DATA_W-1){1'b0}}};
  end

  assign sts.is_query = (op_r == OP_QUERY);
  assign sts.point_bad = (DIM_W'(x_r) >= dim_x_r) || (DIM_W'(y_r) >= dim_y_r) ||
                         (DIM_W'(z_r) >= dim_z_r);
  assign sts.write_bad = wr_word >= GW_LIM;
  assign sts.gather_done = gend_r && !s4_pend;
  assign sts.gather_bad = bad_r;
  assign sts.rank_last = (cj_r == n_r - CNT_W'(1)) || (n_r == '0);
  assign sts.cand_found = eval_hit;
  assign sts.cand_exhausted = (ci_r + CNT_W'(1) >= n_r);

endmodule

>>> src/grid_median_filter_3x3x3.sv
// Write: check, then write, then ready again; no result unless out of range.
// Point out of range: check, error, output, next transfer, with the result taken at once.
// Query: check, gather over the 27 offsets, then per ranked candidate an init, one
// compare a cycle against each window entry, and an evaluation; then done and output.
// Up to 27 neighbours, worst 27 candidates. Result waits in the output register.
// rst_n is synchronous, active low: dims return to 1, store contents undefined.
module grid_median_filter_3x3x3
  import gmf_pkg::*;
#(
  parameter int GRID_WORDS = GRID_WORDS_DEF
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [CRD_W-1:0]         in_x_coord,
  input  logic [CRD_W-1:0]         in_y_coord,
  input  logic [CRD_W-1:0]         in_z_coord,
  input  logic signed [DATA_W-1:0] in_sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_median_value,
  output logic [CNT_W-1:0]         out_neighbour_count,
  output logic                     out_range_error
);

  cmd_t cmd;
  sts_t sts;

  gmf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  gmf_dp #(.GRID_WORDS(GRID_WORDS)) u_dp (
    .clk(clk), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rst_n(rst_n), .in_operation(in_operation), .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord), .in_z_coord(in_z_coord), .in_sample_in(in_sample_in),
    .cmd(cmd), .sts(sts), .out_median_value(out_median_value),
    .out_neighbour_count(out_neighbour_count), .out_range_error(out_range_error)
  );

  assign out_valid = cmd.out_valid;

endmodule

>>> src/gmf_checker.sv
module gmf_checker
  import gmf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CNT_W-1:0]  out_neighbour_count,
  input logic              out_range_error
);

  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_neighbour_count == '0)
    else $error("error result with nonzero count");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_neighbour_count <= CNT_W'(WINDOW_MAX) &&
    out_neighbour_count != '0)
    else $error("count out of range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result right after input transfer");

endmodule

bind grid_median_filter_3x3x3 gmf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_neighbour_count(out_neighbour_count), .out_range_error(out_range_error)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench
  import gmf_pkg::*;
();

  localparam int LIMIT_CYCLES = 2000000;
  localparam int STORE_WORDS = GRID_WORDS_DEF;

  typedef struct {
    logic signed [DATA_W-1:0] median;
    logic [CNT_W-1:0]         count;
    logic                     err;
  } median_res_t;

  typedef struct {
    logic                     op;
    logic [CRD_W-1:0]         x;
    logic [CRD_W-1:0]         y;
    logic [CRD_W-1:0]         z;
    logic signed [DATA_W-1:0] sample;
    bit                       known;
    median_res_t              res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [CRD_W-1:0] in_x_coord;
  logic [CRD_W-1:0] in_y_coord;
  logic [CRD_W-1:0] in_z_coord;
  logic signed [DATA_W-1:0] in_sample_in;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_median_value;
  logic [CNT_W-1:0] out_neighbour_count;
  logic out_range_error;

  grid_median_filter_3x3x3 dut (.*);

  // shadow of the block
  int unsigned size_x, size_y, size_z;
  logic signed [DATA_W-1:0] cells [STORE_WORDS];
  logic signed [DATA_W-1:0] window [WINDOW_MAX];
  median_res_t medians_due [$];

  int fails;
  int unsigned cycles;
  int sender_pct, receiver_pct;
  bit hold_req;
  int n_items, n_queries, n_errors, n_results;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [DATA_W-1:0] select_median(int n);
    int half, lo, hi;
    half = n / 2;
    if (n % 2 == 0 && half > 0) half--;
    for (int i = 0; i < n; i++) begin
      lo = 0;
      hi = 0;
      for (int j = 0; j < n; j++) begin
        if (j != i) begin
          if (window[j] <= window[i]) lo++;
          if (window[j] >= window[i]) hi++;
        end
      end
      if (lo >= half && hi >= half) return window[i];
    end
    return window[0];
  endfunction

  function automatic int unsigned word_of(int x, int y, int z);
    return z * size_x * size_y + y * size_x + x;
  endfunction

  // updates the shadow store; returns 1 when the item yields a result
  function automatic bit model_item(logic op, int x, int y, int z,
                                    logic signed [DATA_W-1:0] s,
                                    output median_res_t r);
    int n;
    int unsigned w;
    r = '{median: '0, count: '0, err: 1'b1};
    if (x >= size_x || y >= size_y || z >= size_z) return 1;
    if (op == OP_WRITE) begin
      w = word_of(x, y, z);
      if (w >= STORE_WORDS) return 1;
      cells[w] = s;
      return 0;
    end
    n = 0;
    for (int i = x - 1; i <= x + 1; i++) begin
      for (int j = y - 1; j <= y + 1; j++) begin
        for (int k = z - 1; k <= z + 1; k++) begin
          if (i >= 0 && i < size_x && j >= 0 && j < size_y && k >= 0 && k < size_z) begin
            w = word_of(i, j, k);
            if (w >= STORE_WORDS) return 1;
            window[n] = cells[w];
            n++;
          end
        end
      end
    end
    r = '{median: select_median(n), count: n[CNT_W-1:0], err: 1'b0};
    return 1;
  endfunction

  task automatic send_item(logic op, int x, int y, int z,
                           logic signed [DATA_W-1:0] s, bit known = 0,
                           median_res_t typed = '{0, 0, 0});
    median_res_t r;
    bit has;
    if ($urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_operation <= op;
    in_x_coord <= x[CRD_W-1:0];
    in_y_coord <= y[CRD_W-1:0];
    in_z_coord <= z[CRD_W-1:0];
    in_sample_in <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = model_item(op, x, y, z, s, r);
    if (known) r = typed;
    if (has) medians_due.push_back(r);
    n_items++;
    if (op == OP_QUERY) n_queries++;
    if (has && r.err) n_errors++;
  endtask

  task automatic set_dims(int dx, int dy, int dz);
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DIM_X;
    cfg_data <= dx[DIM_W-1:0];
    @(posedge clk);
    cfg_index <= REG_DIM_Y;
    cfg_data <= dy[DIM_W-1:0];
    @(posedge clk);
    cfg_index <= REG_DIM_Z;
    cfg_data <= dz[DIM_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_x = dx;
    size_y = dy;
    size_z = dz;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $urandom_range(4) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic int out_coord(int dim);
    return (dim >= 256) ? 0 : $urandom_range(255, dim);
  endfunction

  task automatic fill_grid();
    for (int z = 0; z < size_z; z++)
      for (int y = 0; y < size_y; y++)
        for (int x = 0; x < size_x; x++)
          send_item(OP_WRITE, x, y, z, rand_sample());
  endtask

  task automatic random_items(int count);
    int x, y, z, k;
    for (int i = 0; i < count; i++) begin
      x = $urandom_range(size_x - 1);
      y = $urandom_range(size_y - 1);
      z = $urandom_range(size_z - 1);
      k = $urandom_range(99);
      if (k < 10) begin
        case ($urandom_range(2))
          0: x = out_coord(size_x);
          1: y = out_coord(size_y);
          default: z = out_coord(size_z);
        endcase
        if (x >= size_x || y >= size_y || z >= size_z) begin
          send_item($urandom_range(1), x, y, z, rand_sample());
        end else begin
          send_item(OP_QUERY, x, y, z, rand_sample());
        end
      end else if (k < 45) begin
        send_item(OP_WRITE, x, y, z, rand_sample());
      end else begin
        send_item(OP_QUERY, x, y, z, $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (medians_due.size() == 0) begin
        $error("unexpected result transfer");
        fails++;
      end else begin
        e = medians_due.pop_front();
        if (out_median_value !== e.median) begin
          $error("median_value exp %0d got %0d", e.median, out_median_value);
          fails++;
        end
        if (out_neighbour_count !== e.count) begin
          $error("neighbour_count exp %0d got %0d", e.count, out_neighbour_count);
          fails++;
        end
        if (out_range_error !== e.err) begin
          $error("range_error exp %0d got %0d", e.err, out_range_error);
          fails++;
        end
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end
      out_stall <= ($urandom_range(99) < receiver_pct);
    end
  end

  row_t rows [$];

  initial begin
    int waited;
    fails = 0;
    cycles = 0;
    hold_req = 0;
    sender_pct = 10;
    receiver_pct = 62;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_DIM_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_operation <= OP_WRITE;
    in_x_coord <= '0;
    in_y_coord <= '0;
    in_z_coord <= '0;
    in_sample_in <= '0;
    size_x = 1;
    size_y = 1;
    size_z = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset dims of 1x1x1
    rows = '{
      '{OP_WRITE, 0, 0, 0, 32'sh8000_0000, 0, '{0, 0, 0}},
      '{OP_QUERY, 0, 0, 0, 0, 1, '{32'sh8000_0000, 1, 0}},
      '{OP_WRITE, 0, 0, 0, 32'sh7fff_ffff, 0, '{0, 0, 0}},
      '{OP_QUERY, 0, 0, 0, 32'shffff_ffff, 1, '{32'sh7fff_ffff, 1, 0}},
      '{OP_WRITE, 1, 0, 0, 5, 1, '{0, 0, 1}},
      '{OP_WRITE, 255, 255, 255, 32'shffff_ffff, 1, '{0, 0, 1}},
      '{OP_QUERY, 0, 255, 0, 0, 1, '{0, 0, 1}},
      '{OP_QUERY, 0, 0, 128, 0, 1, '{0, 0, 1}},
      '{OP_QUERY, 255, 255, 255, 0, 1, '{0, 0, 1}},
      '{OP_WRITE, 0, 0, 0, 32'sh0001_0000, 0, '{0, 0, 0}},
      '{OP_QUERY, 0, 0, 0, 0, 1, '{32'sh0001_0000, 1, 0}}
    };
    foreach (rows[i])
      send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].sample,
                rows[i].known, rows[i].res);

    // 2D corners and edges, then 3D
    set_dims(3, 3, 1);
    fill_grid();
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_QUERY, 1, 1, 0, 0);
    send_item(OP_QUERY, 2, 1, 0, 0);
    send_item(OP_QUERY, 3, 0, 0, 0, 1, '{0, 0, 1});
    random_items(60);

    set_dims(4, 4, 4);
    fill_grid();
    hold_req = 1;
    random_items(100);

    sender_pct = 62;
    receiver_pct = 10;
    set_dims(256, 1, 1);
    fill_grid();
    send_item(OP_QUERY, 255, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0);
    random_items(60);

    // beyond the store: rows from 16 up map past the last word
    set_dims(256, 256, 1);
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(3))
        0: send_item(OP_WRITE, $urandom_range(255), $urandom_range(15), 0, rand_sample());
        1: send_item(OP_WRITE, $urandom_range(255), $urandom_range(255, 16), 0,
                     rand_sample());
        2: send_item(OP_QUERY, $urandom_range(255), $urandom_range(255, 17), 0, 0);
        default: send_item($urandom_range(1), $urandom_range(255), $urandom_range(255),
                           $urandom_range(255, 1), rand_sample());
      endcase
    end

    sender_pct = 0;
    receiver_pct = 0;
    set_dims(1, 1, 40);
    fill_grid();
    random_items(40);

    set_dims(5, 3, 2);
    fill_grid();
    random_items(50);

    in_valid <= 1'b0;
    waited = 0;
    while (medians_due.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (1000) @(posedge clk);
    $display("Covered %0d transfers in (%0d queries), %0d results, %0d range errors,",
             n_items, n_queries, n_results, n_errors);
    $display("over 2D, 3D, long-axis and past-the-store grid shapes with back-pressure.");
    if (fails == 0 && medians_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
